/* hw/rtl/vad_pkg.sv */
package vad_pkg;

   // field widths
   localparam int CMP_BITS   = 16;
   localparam int ANGLE_BITS = 16;
   localparam int ANGLE_FRAC_DEFAULT = 8;

   // angle accumulator, degrees with 16 fraction bits
   localparam int ACC_FRAC     = 16;
   localparam int Z_BITS       = 26;
   localparam int ATAN_BITS    = 22;
   localparam int CORDIC_STEPS = 21;
   localparam int Z_QUARTER    = 90 * (1 << ACC_FRAC);
   localparam int Z_HALF       = 180 * (1 << ACC_FRAC);

   // normalization target: larger coordinate reaches bit 40
   localparam int NORM_BIT    = 40;
   localparam int NORM_STEPS  = 6;
   localparam int NORM_STAGES = NORM_STEPS / 2;

   // product and vector widths
   localparam int PROD_DROP = (CMP_BITS > 29) ? 2 * (CMP_BITS - 29) : 0;
   localparam int PROD_BITS = 2 * CMP_BITS - PROD_DROP;
   localparam int DOT_BITS  = PROD_BITS + 1;
   localparam int X_BITS    = ((DOT_BITS > NORM_BIT + 1) ? DOT_BITS : NORM_BIT + 1) + 3;

   // queue depths
   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 32;

   // atan(2^-i) in degrees
   localparam logic [ATAN_BITS-1:0] ATAN_TBL [CORDIC_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
      22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4
   };

   typedef struct packed {
      logic signed [CMP_BITS-1:0] first_x;
      logic signed [CMP_BITS-1:0] first_y;
      logic signed [CMP_BITS-1:0] second_x;
      logic signed [CMP_BITS-1:0] second_y;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_deg;
      logic                  undefined;
   } rsp_type;

   typedef struct packed {
      req_type vec;
      logic    undefined;
   } mid_type;

endpackage

/* hw/rtl/vad_fifo.sv */
module vad_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] head_ff;
   logic             head_vld_ff, head_vld_in;
   logic             pop_acc;
   logic             load;

   // head register is refilled from storage as it drains
   assign pop_acc = pop & head_vld_ff;
   assign load    = (cnt_ff != '0) & (~head_vld_ff | pop_acc);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (load) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in      = cnt_ff + CW'(push) - CW'(load);
      head_vld_in = load | (head_vld_ff & ~pop_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
         head_vld_ff <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
         head_vld_ff <= head_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (load) begin
         head_ff <= mem_ff[rd_ptr_ff];
      end
   end

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = ~head_vld_ff;
   assign pop_data = head_ff;

endmodule

/* hw/rtl/vad_front.sv */
module vad_front (
   input  logic             req_push,
   input  vad_pkg::req_type req_data,
   output logic             req_full,
   output logic             mid_push,
   output vad_pkg::mid_type mid_data,
   input  logic             mid_full
);

   import vad_pkg::*;

   logic first_zero;
   logic second_zero;

   // a zero-length vector has no defined angle
   assign first_zero  = (req_data.first_x == '0) & (req_data.first_y == '0);
   assign second_zero = (req_data.second_x == '0) & (req_data.second_y == '0);

   assign mid_data.vec       = req_data;
   assign mid_data.undefined = first_zero | second_zero;
   assign mid_push           = req_push & ~mid_full;
   assign req_full           = mid_full;

endmodule

/* hw/rtl/vad_back.sv */
module vad_back #(
   parameter int ANGLE_FRACTION_BITS = vad_pkg::ANGLE_FRAC_DEFAULT,
   parameter int OUT_SLOTS = vad_pkg::OUT_DEPTH + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_empty,
   input  vad_pkg::mid_type mid_data,
   output logic             mid_pop,
   input  logic             rsp_taken,
   output logic             out_push,
   output vad_pkg::rsp_type out_data
);

   import vad_pkg::*;

   localparam int RES_BITS  = $clog2(OUT_SLOTS + 1);
   localparam int RND_SH    = ACC_FRAC - ANGLE_FRACTION_BITS;
   localparam int RND_ADD   = (RND_SH > 0) ? (1 << (RND_SH - 1)) : 0;
   localparam int RND_BITS  = Z_BITS;

   // slots reserved in the output queue, taken at issue, freed at delivery
   logic [RES_BITS-1:0] res_ff, res_in;
   logic                issue;

   assign issue   = ~mid_empty & (res_ff < RES_BITS'(OUT_SLOTS));
   assign mid_pop = issue;
   assign res_in  = res_ff + RES_BITS'(issue) - RES_BITS'(rsp_taken);

   // products
   logic                           m_vld_ff;
   logic                           m_und_ff;
   logic signed [2*CMP_BITS-1:0]   m_xx_ff, m_yy_ff, m_xy_ff, m_yx_ff;

   // dot and cross folded into the first quadrant
   logic                    p_vld_ff, p_und_ff, p_zero_ff;
   logic signed [X_BITS-1:0] p_cx_ff, p_cy_ff;
   logic signed [Z_BITS-1:0] p_z_ff;

   logic signed [PROD_BITS-1:0] d_xx, d_yy, d_xy, d_yx;
   logic signed [DOT_BITS-1:0]  dotp, crossp;
   logic signed [X_BITS-1:0]    dot_x, cross_x, cross_abs;
   logic signed [X_BITS-1:0]    p_cx_in, p_cy_in;
   logic signed [Z_BITS-1:0]    p_z_in;

   always_comb begin
      d_xx      = PROD_BITS'(m_xx_ff >>> PROD_DROP);
      d_yy      = PROD_BITS'(m_yy_ff >>> PROD_DROP);
      d_xy      = PROD_BITS'(m_xy_ff >>> PROD_DROP);
      d_yx      = PROD_BITS'(m_yx_ff >>> PROD_DROP);
      dotp      = DOT_BITS'(d_xx) + DOT_BITS'(d_yy);
      crossp    = DOT_BITS'(d_xy) - DOT_BITS'(d_yx);
      dot_x     = X_BITS'(dotp);
      cross_x   = X_BITS'(crossp);
      cross_abs = (cross_x < 0) ? -cross_x : cross_x;
      if (dot_x < 0) begin
         p_cx_in = cross_abs;
         p_cy_in = -dot_x;
         p_z_in  = Z_BITS'(Z_QUARTER);
      end else begin
         p_cx_in = dot_x;
         p_cy_in = cross_abs;
         p_z_in  = '0;
      end
   end

   // normalization, two shift steps per stage
   logic                     n_vld_ff  [NORM_STAGES];
   logic                     n_und_ff  [NORM_STAGES];
   logic                     n_zero_ff [NORM_STAGES];
   logic signed [X_BITS-1:0] n_cx_ff   [NORM_STAGES];
   logic signed [X_BITS-1:0] n_cy_ff   [NORM_STAGES];
   logic signed [Z_BITS-1:0] n_z_ff    [NORM_STAGES];

   logic                     n_vld_src  [NORM_STAGES];
   logic                     n_und_src  [NORM_STAGES];
   logic                     n_zero_src [NORM_STAGES];
   logic signed [Z_BITS-1:0] n_z_src    [NORM_STAGES];
   logic signed [X_BITS-1:0] n_cx_src  [NORM_STAGES];
   logic signed [X_BITS-1:0] n_cy_src  [NORM_STAGES];
   logic signed [X_BITS-1:0] n_cx_in   [NORM_STAGES];
   logic signed [X_BITS-1:0] n_cy_in   [NORM_STAGES];

   // cordic rotations
   logic                     c_vld_ff  [CORDIC_STEPS];
   logic                     c_und_ff  [CORDIC_STEPS];
   logic                     c_zero_ff [CORDIC_STEPS];
   logic signed [X_BITS-1:0] c_cx_ff   [CORDIC_STEPS];
   logic signed [X_BITS-1:0] c_cy_ff   [CORDIC_STEPS];
   logic signed [Z_BITS-1:0] c_z_ff    [CORDIC_STEPS];

   logic                     c_vld_src  [CORDIC_STEPS];
   logic                     c_und_src  [CORDIC_STEPS];
   logic                     c_zero_src [CORDIC_STEPS];
   logic signed [X_BITS-1:0] c_cx_src   [CORDIC_STEPS];
   logic signed [X_BITS-1:0] c_cy_src   [CORDIC_STEPS];
   logic signed [Z_BITS-1:0] c_z_src    [CORDIC_STEPS];
   logic signed [X_BITS-1:0] c_cx_in    [CORDIC_STEPS];
   logic signed [X_BITS-1:0] c_cy_in    [CORDIC_STEPS];
   logic signed [Z_BITS-1:0] c_z_in     [CORDIC_STEPS];

   genvar gj, gi;

   generate
      for (gj = 0; gj < NORM_STAGES; gj++) begin : g_norm
         if (gj == 0) begin : g_first
            assign n_vld_src[gj]  = p_vld_ff;
            assign n_und_src[gj]  = p_und_ff;
            assign n_zero_src[gj] = p_zero_ff;
            assign n_z_src[gj]    = p_z_ff;
            assign n_cx_src[gj]   = p_cx_ff;
            assign n_cy_src[gj]   = p_cy_ff;
         end else begin : g_next
            assign n_vld_src[gj]  = n_vld_ff[gj-1];
            assign n_und_src[gj]  = n_und_ff[gj-1];
            assign n_zero_src[gj] = n_zero_ff[gj-1];
            assign n_z_src[gj]    = n_z_ff[gj-1];
            assign n_cx_src[gj]   = n_cx_ff[gj-1];
            assign n_cy_src[gj]   = n_cy_ff[gj-1];
         end

         always_comb begin
            logic signed [X_BITS-1:0] ax;
            logic signed [X_BITS-1:0] ay;
            int                       k;
            ax = n_cx_src[gj];
            ay = n_cy_src[gj];
            for (int s = 0; s < 2; s++) begin
               k = 1 << (NORM_STEPS - 1 - (2 * gj + s));
               if (((ax | ay) >> (NORM_BIT + 1 - k)) == '0) begin
                  ax = ax <<< k;
                  ay = ay <<< k;
               end
            end
            n_cx_in[gj] = ax;
            n_cy_in[gj] = ay;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               n_vld_ff[gj] <= 1'b0;
            end else begin
               n_vld_ff[gj] <= n_vld_src[gj];
            end
         end

         always_ff @(posedge clock) begin
            n_cx_ff[gj]   <= n_cx_in[gj];
            n_cy_ff[gj]   <= n_cy_in[gj];
            n_und_ff[gj]  <= n_und_src[gj];
            n_zero_ff[gj] <= n_zero_src[gj];
            n_z_ff[gj]    <= n_z_src[gj];
         end
      end

      for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
         if (gi == 0) begin : g_first
            assign c_vld_src[gi]  = n_vld_ff[NORM_STAGES-1];
            assign c_und_src[gi]  = n_und_ff[NORM_STAGES-1];
            assign c_zero_src[gi] = n_zero_ff[NORM_STAGES-1];
            assign c_cx_src[gi]   = n_cx_ff[NORM_STAGES-1];
            assign c_cy_src[gi]   = n_cy_ff[NORM_STAGES-1];
            assign c_z_src[gi]    = n_z_ff[NORM_STAGES-1];
         end else begin : g_next
            assign c_vld_src[gi]  = c_vld_ff[gi-1];
            assign c_und_src[gi]  = c_und_ff[gi-1];
            assign c_zero_src[gi] = c_zero_ff[gi-1];
            assign c_cx_src[gi]   = c_cx_ff[gi-1];
            assign c_cy_src[gi]   = c_cy_ff[gi-1];
            assign c_z_src[gi]    = c_z_ff[gi-1];
         end

         // rotate toward the x axis
         always_comb begin
            logic signed [X_BITS-1:0] sx;
            logic signed [X_BITS-1:0] sy;
            sx = c_cx_src[gi] >>> gi;
            sy = c_cy_src[gi] >>> gi;
            if (c_cy_src[gi] >= 0) begin
               c_cx_in[gi] = c_cx_src[gi] + sy;
               c_cy_in[gi] = c_cy_src[gi] - sx;
               c_z_in[gi]  = c_z_src[gi] + Z_BITS'(ATAN_TBL[gi]);
            end else begin
               c_cx_in[gi] = c_cx_src[gi] - sy;
               c_cy_in[gi] = c_cy_src[gi] + sx;
               c_z_in[gi]  = c_z_src[gi] - Z_BITS'(ATAN_TBL[gi]);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               c_vld_ff[gi] <= 1'b0;
            end else begin
               c_vld_ff[gi] <= c_vld_src[gi];
            end
         end

         always_ff @(posedge clock) begin
            c_und_ff[gi]  <= c_und_src[gi];
            c_zero_ff[gi] <= c_zero_src[gi];
            c_cx_ff[gi]   <= c_cx_in[gi];
            c_cy_ff[gi]   <= c_cy_in[gi];
            c_z_ff[gi]    <= c_z_in[gi];
         end
      end
   endgenerate

   // clamp, round, flag
   logic                     f_vld_ff;
   rsp_type                  f_data_ff, f_data_in;
   logic signed [Z_BITS-1:0] z_last;
   logic [RND_BITS-1:0]      z_clamp;
   logic [RND_BITS-1:0]      z_round;

   always_comb begin
      z_last = c_z_ff[CORDIC_STEPS-1];
      if (z_last < 0) begin
         z_clamp = '0;
      end else if (z_last > Z_BITS'(Z_HALF)) begin
         z_clamp = RND_BITS'(Z_HALF);
      end else begin
         z_clamp = RND_BITS'(z_last);
      end
      z_round = (z_clamp + RND_BITS'(RND_ADD)) >> RND_SH;
      if (c_und_ff[CORDIC_STEPS-1]) begin
         f_data_in.angle_deg = '0;
         f_data_in.undefined = 1'b1;
      end else if (c_zero_ff[CORDIC_STEPS-1]) begin
         f_data_in.angle_deg = '0;
         f_data_in.undefined = 1'b0;
      end else begin
         f_data_in.angle_deg = z_round[ANGLE_BITS-1:0];
         f_data_in.undefined = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff   <= '0;
         m_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else begin
         res_ff   <= res_in;
         m_vld_ff <= issue;
         p_vld_ff <= m_vld_ff;
         f_vld_ff <= c_vld_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      m_und_ff  <= mid_data.undefined;
      m_xx_ff   <= mid_data.vec.first_x * mid_data.vec.second_x;
      m_yy_ff   <= mid_data.vec.first_y * mid_data.vec.second_y;
      m_xy_ff   <= mid_data.vec.first_x * mid_data.vec.second_y;
      m_yx_ff   <= mid_data.vec.first_y * mid_data.vec.second_x;
      p_und_ff  <= m_und_ff;
      p_zero_ff <= (p_cx_in == '0) & (p_cy_in == '0);
      p_cx_ff   <= p_cx_in;
      p_cy_ff   <= p_cy_in;
      p_z_ff    <= p_z_in;
      f_data_ff <= f_data_in;
   end

   assign out_push = f_vld_ff;
   assign out_data = f_data_ff;

endmodule

/* hw/rtl/vector_angle_degrees.sv */
// Unsigned angle between two 2D vectors given as signed Q8.8 components, returned in
// degrees as unsigned Q8.8 from 0 to 180 (fraction bits set by ANGLE_FRACTION_BITS).
// The angle is found as atan2(|cross|, dot) with a 21-step vectoring cordic, so the
// cosine never leaves -1..1 and no square root is taken; a zero-length vector gives
// undefined = 1 and angle 0. One request is accepted every cycle while a result slot
// is free, and one result leaves every cycle while rsp_pop is held: the arithmetic is
// a 27-stage pipeline (products, quadrant fold, three normalize stages, one cordic
// rotation per stage, round). A request passes through the mid queue's storage and
// head register, that pipeline, and the result queue's storage and head register.
// A three-entry mid queue and a 33-entry result queue decouple the sides; requests keep
// flowing while results wait; push stalls only once every result slot is reserved.
module vector_angle_degrees #(
   parameter int ANGLE_FRACTION_BITS = vad_pkg::ANGLE_FRAC_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             req_push,
   input  vad_pkg::req_type req_data,
   output logic             req_full,
   // result side
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output vad_pkg::rsp_type rsp_data
);

   import vad_pkg::*;

   // front end to mid queue
   logic    mid_push;
   mid_type mid_in;
   logic    mid_full;
   // mid queue to back end
   mid_type mid_out;
   logic    mid_empty;
   logic    mid_pop;
   // back end to result queue
   logic    out_push;
   rsp_type out_data;
   logic    out_full;
   logic    rsp_taken;

   assign rsp_taken = rsp_pop & ~rsp_empty;

   // classify: flag zero-length vectors
   vad_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .mid_push (mid_push),
      .mid_data (mid_in),
      .mid_full (mid_full)
   );

   // short queue that lets the front end run while the back end holds
   vad_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   // arithmetic pipeline, issues only against a reserved result slot
   vad_back #(
      .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
      .OUT_SLOTS           (OUT_DEPTH + 1)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_out),
      .mid_pop   (mid_pop),
      .rsp_taken (rsp_taken),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // result queue, storage plus head register gives OUT_DEPTH + 1 slots
   vad_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   // slot reservation must keep the result queue from overflowing
   a_out_no_overflow : assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full queue");

   // back end never pops an empty mid queue
   a_mid_pop_valid : assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("mid queue popped while empty");

   // an undefined result always reports angle zero
   a_undefined_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.undefined) |-> (rsp_data.angle_deg == '0))
      else $error("undefined result with nonzero angle");

endmodule
